// ===== rtl/pcq_pkg.sv =====
// Shared types, constants and the divider step for the per-channel quantiser.
// No dependencies.
package pcq_pkg;

  localparam int MANT_W     = 53;
  localparam int QUO_W      = 56;
  localparam int REM_W      = 54;
  localparam int EXP_W      = 13;
  localparam int IVAL_W     = 35;
  localparam int CALC_W     = 36;
  localparam int BITS_PER_CYC = 2;
  localparam int DIV_CYCLES = QUO_W / BITS_PER_CYC;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_W     = 3'd5;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic signed [EXP_W-1:0] EXP_OFFSET = 13'sd1075;
  localparam logic signed [EXP_W-1:0] SAT_EXP    = -13'sd19;
  localparam logic signed [EXP_W-1:0] ZERO_SHIFT = 13'sd54;

  typedef struct packed {
    logic wr_scale;
    logic load;
    logic unpack;
    logic norm;
    logic div_step;
    logic rnd;
    logic int_rnd;
    logic fin;
  } pcq_cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic div_last;
    logic out_free;
  } pcq_sts_t;

  // one restoring step: returns {quotient bit, shifted remainder}
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic [MANT_W-1:0] den);
    logic [REM_W:0]   diff;
    logic             qb;
    logic [REM_W-1:0] r;
    diff = {1'b0, rem} - {2'b00, den};
    qb   = ~diff[REM_W];
    r    = qb ? diff[REM_W-1:0] : rem;
    return {qb, r[REM_W-2:0], 1'b0};
  endfunction

endpackage

// ===== rtl/pcq_if.sv =====
// Valid/ready channel interfaces for the quantiser's element and result items.
// No dependencies.
interface pcq_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] real_value;
  logic [7:0]  scale_index;
  logic        last_element;
  modport source (output valid, req_type, real_value, scale_index, last_element,
                  input ready);
  modport sink (input valid, req_type, real_value, scale_index, last_element,
                output ready);
endinterface

interface pcq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quantised_value;
  logic               invalid_input;
  logic               last_result;
  modport source (output valid, quantised_value, invalid_input, last_result,
                  input ready);
  modport sink (input valid, quantised_value, invalid_input, last_result,
                output ready);
endinterface

// ===== rtl/pcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pcq_ctrl.sv =====
// Sequencing state machine for the quantiser.
// Depends on pcq_pkg; drives pcq_dp through pcq_cmd_t.
module pcq_ctrl import pcq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  pcq_sts_t sts,
  output pcq_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_NORM = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_RND  = 7'b0010000,
    ST_INT  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type) begin
            cmd.wr_scale = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.unpack = 1'b1;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        if (sts.special) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.norm = 1'b1;
          if (sts.norm_done) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.int_rnd = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pcq_dp.sv =====
// Datapath: config registers, channel counters, scale table, binary64 divider,
// rounding, clamp and the result register. Depends on pcq_pkg and pcq_ram.
module pcq_dp import pcq_pkg::*; #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [63:0]           in_real_value,
  input  logic [7:0]            in_scale_index,
  input  logic                  in_last_element,
  input  pcq_cmd_t              cmd,
  output pcq_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_quantised_value,
  output logic                  out_invalid_input,
  output logic                  out_last_result
);

  localparam int CH_W   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_CW = $clog2(MAX_CHANNELS + 1) + 1;

  // configuration
  logic        part_mode_r;
  logic [24:0] axis_stride_r;
  logic [8:0]  chan_count_r;
  logic [31:0] zero_point_r;
  logic        narrow_r;
  logic [5:0]  store_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_mode_r   <= 1'b0;
      axis_stride_r <= 25'd1;
      chan_count_r  <= 9'd1;
      zero_point_r  <= '0;
      narrow_r      <= 1'b0;
      store_w_r     <= 6'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PART_MODE:   part_mode_r   <= cfg_wdata[0];
        CFG_AXIS_STRIDE: axis_stride_r <= cfg_wdata[24:0];
        CFG_CHAN_COUNT:  chan_count_r  <= cfg_wdata[8:0];
        CFG_ZERO_POINT:  zero_point_r  <= cfg_wdata;
        CFG_NARROW:      narrow_r      <= cfg_wdata[0];
        CFG_STORE_W:     store_w_r     <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // channel indexing
  logic [23:0]     stride_pos_r;
  logic [CH_W-1:0] chan_pos_r;
  logic [24:0]     stride_lim;
  logic [24:0]     stride_inc;
  logic [CNT_CW-1:0] chan_lim;
  logic [CNT_CW-1:0] chan_inc;

  always_comb begin
    if (axis_stride_r == '0) begin
      stride_lim = 25'd1;
    end else if (axis_stride_r > 25'd16777216) begin
      stride_lim = 25'd16777216;
    end else begin
      stride_lim = axis_stride_r;
    end
    if (chan_count_r == '0) begin
      chan_lim = CNT_CW'(1);
    end else if (CNT_CW'(chan_count_r) > CNT_CW'(MAX_CHANNELS)) begin
      chan_lim = CNT_CW'(MAX_CHANNELS);
    end else begin
      chan_lim = CNT_CW'(chan_count_r);
    end
    stride_inc = {1'b0, stride_pos_r} + 25'd1;
    chan_inc   = CNT_CW'(chan_pos_r) + CNT_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_pos_r <= '0;
      chan_pos_r   <= '0;
    end else if (cmd.load) begin
      if (in_last_element) begin
        stride_pos_r <= '0;
        chan_pos_r   <= '0;
      end else if (stride_inc >= stride_lim) begin
        stride_pos_r <= '0;
        chan_pos_r   <= (chan_inc >= chan_lim) ? '0 : chan_pos_r + CH_W'(1);
      end else begin
        stride_pos_r <= stride_inc[23:0];
      end
    end
  end

  // scale table
  logic [63:0]     scale_rd;
  logic            tbl_we;
  logic [CH_W-1:0] tbl_raddr;

  assign tbl_we    = cmd.wr_scale && (int'(in_scale_index) < MAX_CHANNELS);
  assign tbl_raddr = part_mode_r ? chan_pos_r : '0;

  pcq_ram #(.WIDTH(64), .DEPTH(MAX_CHANNELS)) u_scale_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (CH_W'(in_scale_index)),
    .wdata (in_real_value),
    .re    (cmd.load),
    .raddr (tbl_raddr),
    .rdata (scale_rd)
  );

  // element registers
  logic [63:0]             real_r;
  logic                    last_r;
  logic                    special_r, nan_r, sat_r, sat_neg_r, sign_r;
  logic [MANT_W-1:0]       rm_r, sm_r, m_r;
  logic signed [EXP_W-1:0] re_r, se_r, e_r;
  logic [REM_W-1:0]        rem_r;
  logic [QUO_W-1:0]        quo_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic [IVAL_W-1:0]       ival_r;

  // unpack
  logic [10:0] r_exp, s_exp;
  logic        r_nan, r_inf, r_zero, s_nan, s_inf, s_zero;
  logic        u_nan, u_sat, u_zero;

  always_comb begin
    r_exp  = real_r[62:52];
    s_exp  = scale_rd[62:52];
    r_nan  = (r_exp == EXP_ALL_ONES) && (real_r[51:0] != '0);
    r_inf  = (r_exp == EXP_ALL_ONES) && (real_r[51:0] == '0);
    r_zero = (r_exp == '0) && (real_r[51:0] == '0);
    s_nan  = (s_exp == EXP_ALL_ONES) && (scale_rd[51:0] != '0);
    s_inf  = (s_exp == EXP_ALL_ONES) && (scale_rd[51:0] == '0);
    s_zero = (s_exp == '0) && (scale_rd[51:0] == '0);
    u_nan  = r_nan || s_nan || (r_zero && s_zero) || (r_inf && s_inf);
    u_sat  = !u_nan && (s_zero || r_inf);
    u_zero = !u_nan && !u_sat && (r_zero || s_inf);
  end

  // divider
  logic [REM_W:0] step1, step2;
  assign step1 = div_step(rem_r, sm_r);
  assign step2 = div_step(step1[REM_W-1:0], sm_r);

  // mantissa rounding
  logic [MANT_W-1:0]       rn_m;
  logic                    rn_g, rn_st, rn_up;
  logic [MANT_W:0]         rn_sum;
  logic signed [EXP_W-1:0] rn_e;

  always_comb begin
    if (quo_r[QUO_W-1]) begin
      rn_m  = quo_r[QUO_W-1:3];
      rn_g  = quo_r[2];
      rn_st = (quo_r[1:0] != '0) || (rem_r != '0);
      rn_e  = re_r - se_r - 13'sd52;
    end else begin
      rn_m  = quo_r[QUO_W-2:2];
      rn_g  = quo_r[1];
      rn_st = quo_r[0] || (rem_r != '0);
      rn_e  = re_r - se_r - 13'sd53;
    end
    rn_up  = rn_g && (rn_st || rn_m[0]);
    rn_sum = {1'b0, rn_m} + (MANT_W+1)'(rn_up);
  end

  // integer rounding
  logic signed [EXP_W-1:0] ir_n;
  logic [2*MANT_W:0]       ir_x;
  logic [32:0]             ir_i;
  logic                    ir_up;
  logic [33:0]             ir_mag;
  logic [IVAL_W-1:0]       ir_val;

  always_comb begin
    ir_n   = -e_r;
    ir_x   = {m_r, 54'd0} >> ir_n[5:0];
    ir_i   = ir_x[86:54];
    ir_up  = ir_x[53] && ((ir_x[52:0] != '0) || ir_i[0]);
    ir_mag = {1'b0, ir_i} + 34'(ir_up);
    ir_val = sign_r ? -IVAL_W'(ir_mag) : IVAL_W'(ir_mag);
  end

  // add zero point and clamp
  logic [5:0]        w_eff;
  logic [CALC_W-1:0] qmax, qmin, zp_x, sum_x, res_x;

  always_comb begin
    if (store_w_r < 6'd2) begin
      w_eff = 6'd2;
    end else if (store_w_r > 6'd32) begin
      w_eff = 6'd32;
    end else begin
      w_eff = store_w_r;
    end
    qmax  = (CALC_W'(1) << (w_eff - 6'd1)) - CALC_W'(1);
    qmin  = ~qmax + CALC_W'(narrow_r);
    zp_x  = {{(CALC_W-32){zero_point_r[31]}}, zero_point_r};
    sum_x = nan_r ? zp_x : {ival_r[IVAL_W-1], ival_r} + zp_x;
    if (sat_r) begin
      res_x = sat_neg_r ? qmin : qmax;
    end else if ($signed(sum_x) < $signed(qmin)) begin
      res_x = qmin;
    end else if ($signed(sum_x) > $signed(qmax)) begin
      res_x = qmax;
    end else begin
      res_x = sum_x;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      real_r <= in_real_value;
      last_r <= in_last_element;
    end
    if (cmd.unpack) begin
      special_r <= u_nan || u_sat || u_zero;
      nan_r     <= u_nan;
      sat_r     <= u_sat;
      sat_neg_r <= real_r[63] ^ scale_rd[63];
      sign_r    <= real_r[63] ^ scale_rd[63];
      ival_r    <= '0;
      rm_r      <= {r_exp != '0, real_r[51:0]};
      sm_r      <= {s_exp != '0, scale_rd[51:0]};
      re_r      <= $signed({2'b00, (r_exp == '0) ? 11'd1 : r_exp}) - EXP_OFFSET;
      se_r      <= $signed({2'b00, (s_exp == '0) ? 11'd1 : s_exp}) - EXP_OFFSET;
    end
    if (cmd.norm) begin
      if (!rm_r[MANT_W-1]) begin
        rm_r <= {rm_r[MANT_W-2:0], 1'b0};
        re_r <= re_r - 13'sd1;
      end
      if (!sm_r[MANT_W-1]) begin
        sm_r <= {sm_r[MANT_W-2:0], 1'b0};
        se_r <= se_r - 13'sd1;
      end
      rem_r  <= {1'b0, rm_r};
      quo_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r  <= {quo_r[QUO_W-3:0], step1[REM_W], step2[REM_W]};
      rem_r  <= step2[REM_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.rnd) begin
      if (rn_sum[MANT_W]) begin
        m_r <= rn_sum[MANT_W:1];
        e_r <= rn_e + 13'sd1;
      end else begin
        m_r <= rn_sum[MANT_W-1:0];
        e_r <= rn_e;
      end
    end
    if (cmd.int_rnd) begin
      if (e_r >= SAT_EXP) begin
        sat_r     <= 1'b1;
        sat_neg_r <= sign_r;
      end else if (ir_n >= ZERO_SHIFT) begin
        ival_r <= '0;
      end else begin
        ival_r <= ir_val;
      end
    end
    if (cmd.fin) begin
      out_quantised_value <= $signed(res_x[31:0]);
      out_invalid_input   <= nan_r;
      out_last_result     <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.special   = special_r;
  assign sts.norm_done = rm_r[MANT_W-1] && sm_r[MANT_W-1];
  assign sts.div_last  = (dcnt_r == DCNT_W'(DIV_CYCLES - 1));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/per_channel_quantiser.sv =====
// Per-channel affine quantiser: binary64 elements in, clamped signed codes out.
// A scale-table write is done on acceptance. An element item passes through
// accept, scale table read, mantissa normalization, the two-bit-per-cycle
// restoring divider, then mantissa rounding, integer rounding and zero-point
// clamp. NaN, infinity, zero-element and zero-scale items skip normalization, the
// divider and both rounding steps. The last step also waits while the previous
// result is still held. The next item is accepted while a result waits in the
// output register.
// Depends on pcq_pkg, pcq_if, pcq_ctrl, pcq_dp.
module per_channel_quantiser import pcq_pkg::*; #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pcq_in_if.sink                in_ch,
  pcq_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pcq_cmd_t cmd;
  pcq_sts_t sts;

  pcq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pcq_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_real_value       (in_ch.real_value),
    .in_scale_index      (in_ch.scale_index),
    .in_last_element     (in_ch.last_element),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_quantised_value (out_ch.quantised_value),
    .out_invalid_input   (out_ch.invalid_input),
    .out_last_result     (out_ch.last_result)
  );

  a_elem_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.req_type |=> !in_ch.ready)
    else $error("element accepted back to back");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.unpack, cmd.norm, cmd.div_step, cmd.rnd,
              cmd.int_rnd, cmd.fin}))
    else $error("overlapping datapath commands");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_ch.valid)
    else $error("finished item not presented");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

endmodule
